@@ hdl/gble_pkg.sv @@
// ----------------------------------------------------------------------------
// gble_pkg
// Shared constants for the gap buffer line editor: request codes, status
// codes, character codes, stream widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package gble_pkg;

    localparam int GBLE_CAPACITY  = 4096;
    localparam int GBLE_MAX_LINES = 1024;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;

    localparam logic [2:0] OP_SET_CURSOR = 3'd0;
    localparam logic [2:0] OP_INSERT     = 3'd1;
    localparam logic [2:0] OP_DELETE     = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [10:0] CURSOR_LINE_MAX = 11'd2047;
    localparam logic [11:0] CURSOR_COL_MAX  = 12'd4095;

    typedef enum logic [1:0] {
        PU_EDIT,
        PU_READ,
        PU_FIN
    } purpose_t;

endpackage

`default_nettype wire

@@ hdl/gap_buffer_line_editor.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// Text gap buffer with a line start table, both held in synchronous memories
// and edited by a sequencer that reads, modifies and writes back.
// ----------------------------------------------------------------------------
// Each request gives one result, and every request ends by finding the
// cursor line length. The first edit after a cursor move walks the whole
// line table and moves the text between old and new gap position; each pad
// byte adds an insert. A newline insert shifts the line entries after the
// cursor, and a delete that removes text walks the line table. These walks
// follow from the single read and single write port of each memory. After
// reset the block writes the first line table entries before it takes its
// first request.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_line_editor
    import gble_pkg::*;
#(
    parameter int CAPACITY  = GBLE_CAPACITY,
    parameter int MAX_LINES = GBLE_MAX_LINES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // line_number[10:0], column[22:11], char_code[30:23], delete_count[43:31]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // op[2:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // char_out[7:0], char_valid[8], line_length[20:9], line_total[31:21],
    // char_total[43:32], status[45:44]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int PW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(MAX_LINES + 1);
    localparam int EW  = $clog2(MAX_LINES + 2);
    localparam int MW0 = (PW > EW) ? PW : EW;
    localparam int NW  = ((MW0 > 13) ? MW0 : 13) + 2;

    typedef enum logic [22:0] {
        S_INIT0   = 23'd1 << 0,
        S_INIT1   = 23'd1 << 1,
        S_IDLE    = 23'd1 << 2,
        S_EDIT    = 23'd1 << 3,
        S_PR_A    = 23'd1 << 4,
        S_PR_B    = 23'd1 << 5,
        S_PR_C    = 23'd1 << 6,
        S_ED_CHK  = 23'd1 << 7,
        S_MG_RD   = 23'd1 << 8,
        S_MG_WR   = 23'd1 << 9,
        S_MV_RD   = 23'd1 << 10,
        S_MV_WR   = 23'd1 << 11,
        S_PUT_SEL = 23'd1 << 12,
        S_PC_WR   = 23'd1 << 13,
        S_NL_RD   = 23'd1 << 14,
        S_NL_CMP  = 23'd1 << 15,
        S_BODY    = 23'd1 << 16,
        S_DW_RD   = 23'd1 << 17,
        S_DW_WR   = 23'd1 << 18,
        S_RD_CHK  = 23'd1 << 19,
        S_RD_CAP  = 23'd1 << 20,
        S_FIN     = 23'd1 << 21,
        S_OUT     = 23'd1 << 22
    } state_t;

    function automatic logic [PW-1:0] to_log(input logic [PW-1:0] v,
                                            input logic [PW-1:0] g,
                                            input logic [PW-1:0] l);
        return (v <= g) ? v : v - l;
    endfunction

    // memories
    logic [7:0]    txt_mem [CAPACITY];
    logic [PW-1:0] tbl_mem [MAX_LINES + 1];

    logic          txt_we;
    logic [AW-1:0] txt_waddr, txt_raddr;
    logic [7:0]    txt_wdata, txt_rdata_reg;
    logic          tbl_we;
    logic [IW-1:0] tbl_waddr, tbl_raddr;
    logic [PW-1:0] tbl_wdata, tbl_rdata_reg;

    always_ff @(posedge aclk) begin
        if (txt_we) begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        txt_rdata_reg <= txt_mem[txt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // control state
    state_t         state_reg, state_next;
    logic [PW-1:0]  gb_reg, gb_next, gl_reg, gl_next;
    logic [10:0]    cl_reg, cl_next;
    logic [11:0]    cc_reg, cc_next;
    logic           dirty_reg, dirty_next;
    logic [EW-1:0]  ent_reg, ent_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // working registers
    purpose_t       purpose_reg, purpose_next;
    logic [2:0]     op_reg, op_next;
    logic [11:0]    col_reg, col_next;
    logic [7:0]     ch_reg, ch_next;
    logic [12:0]    dc_reg, dc_next;
    logic [IW-1:0]  pidx_reg, pidx_next;
    logic [PW-1:0]  ra_reg, ra_next, rb_reg, rb_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [10:0]    nl_rem_reg, nl_rem_next;
    logic [11:0]    sp_rem_reg, sp_rem_next;
    logic [11:0]    ecol_reg, ecol_next;
    logic [EW-1:0]  idx_reg, idx_next, k_reg, k_next;
    logic [AW-1:0]  src_reg, src_next, dst_reg, dst_next;
    logic [PW-1:0]  cnt_reg, cnt_next;
    logic           down_reg, down_next;
    logic [PW-1:0]  lo_reg, lo_next, n_reg, n_next;
    logic [7:0]     pc_char_reg, pc_char_next;
    logic           pc_edit_reg, pc_edit_next;
    logic [1:0]     status_reg, status_next;
    logic [7:0]     cout_reg, cout_next;
    logic           cval_reg, cval_next;
    logic [11:0]    len_reg, len_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // request fields
    logic [2:0]  in_op;
    logic [10:0] in_ln;
    logic [11:0] in_col;
    logic [7:0]  in_ch;
    logic [12:0] in_dc;

    assign in_op  = s_tuser[2:0];
    assign in_ln  = s_tdata[10:0];
    assign in_col = s_tdata[22:11];
    assign in_ch  = s_tdata[30:23];
    assign in_dc  = s_tdata[43:31];

    // shared arithmetic
    logic [PW-1:0] tlen, la, lb, pair_len, rd;
    logic [EW-1:0] lines;

    assign rd       = tbl_rdata_reg;
    assign tlen     = PW'(CAPACITY - 1) - gl_reg;
    assign la       = to_log(ra_reg, gb_reg, gl_reg);
    assign lb       = to_log(rb_reg, gb_reg, gl_reg);
    assign pair_len = (lb > la) ? lb - la - PW'(1) : '0;
    assign lines    = ent_reg - EW'(1);

    logic          ed_beyond, ed_refuse;
    logic [NW-1:0] ed_need;
    assign ed_beyond = NW'(cl_reg) > NW'(lines);
    assign ed_need   = NW'(cl_reg) - NW'(lines) + NW'(cc_reg);
    assign ed_refuse = (NW'(cl_reg) > NW'(MAX_LINES)) || (ed_need > NW'(gl_reg));

    logic          ck_over;
    logic [NW-1:0] ck_pad;
    logic [PW-1:0] ck_pos;
    assign ck_over = NW'(ecol_reg) > NW'(pair_len);
    assign ck_pad  = ck_over ? NW'(ecol_reg) - NW'(pair_len) : '0;
    assign ck_pos  = la + (ck_over ? pair_len : PW'(ecol_reg));

    logic [PW-1:0] mg_l, mg_new;
    assign mg_l   = to_log(rd, gb_reg, gl_reg);
    assign mg_new = (mg_l <= pos_reg) ? mg_l : mg_l + gl_reg;

    logic          mv_down;
    logic [PW-1:0] mv_cnt;
    assign mv_down = pos_reg < gb_reg;
    assign mv_cnt  = mv_down ? gb_reg - pos_reg : pos_reg - gb_reg;

    logic          dl_back;
    logic [NW-1:0] dl_mag, dl_bn, dl_avail, dl_fn;
    logic [PW-1:0] dl_n;
    assign dl_back  = dc_reg[12];
    assign dl_mag   = NW'(14'h2000) - NW'(dc_reg);
    assign dl_bn    = (dl_mag < NW'(gb_reg)) ? dl_mag : NW'(gb_reg);
    assign dl_avail = NW'(tlen) - NW'(gb_reg);
    assign dl_fn    = (NW'(dc_reg) < dl_avail) ? NW'(dc_reg) : dl_avail;
    assign dl_n     = PW'(dl_back ? dl_bn : dl_fn);

    logic dw_drop;
    assign dw_drop = (rd != '0) && ((rd - PW'(1)) >= lo_reg)
                     && ((rd - PW'(1)) < (lo_reg + n_reg));

    logic          rq_bad, rd_bad, rd_in;
    logic [NW-1:0] rd_p, rd_phys;
    assign rq_bad  = (in_ln == '0) || (NW'(in_ln) >= NW'(ent_reg));
    assign rd_bad  = NW'(col_reg) > NW'(pair_len);
    assign rd_p    = NW'(la) + NW'(col_reg);
    assign rd_in   = rd_p < NW'(tlen);
    assign rd_phys = (rd_p < NW'(gb_reg)) ? rd_p : rd_p + NW'(gl_reg);

    logic fin_none, ins_full;
    assign fin_none = (cl_reg == '0) || (NW'(cl_reg) >= NW'(ent_reg));
    assign ins_full = (gl_reg == '0)
                      || ((ch_reg == CH_NEWLINE) && (NW'(ent_reg) > NW'(MAX_LINES)));

    state_t pc_ret;
    assign pc_ret = pc_edit_reg ? S_PUT_SEL : S_FIN;

    always_comb begin
        state_next    = state_reg;
        gb_next       = gb_reg;
        gl_next       = gl_reg;
        cl_next       = cl_reg;
        cc_next       = cc_reg;
        dirty_next    = dirty_reg;
        ent_next      = ent_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        purpose_next  = purpose_reg;
        op_next       = op_reg;
        col_next      = col_reg;
        ch_next       = ch_reg;
        dc_next       = dc_reg;
        pidx_next     = pidx_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        pos_next      = pos_reg;
        nl_rem_next   = nl_rem_reg;
        sp_rem_next   = sp_rem_reg;
        ecol_next     = ecol_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cnt_next      = cnt_reg;
        down_next     = down_reg;
        lo_next       = lo_reg;
        n_next        = n_reg;
        pc_char_next  = pc_char_reg;
        pc_edit_next  = pc_edit_reg;
        status_next   = status_reg;
        cout_next     = cout_reg;
        cval_next     = cval_reg;
        len_next      = len_reg;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        txt_we        = 1'b0;
        txt_waddr     = AW'(gb_reg);
        txt_wdata     = pc_char_reg;
        txt_raddr     = src_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = idx_reg[IW-1:0];
        tbl_wdata     = rd;
        tbl_raddr     = idx_reg[IW-1:0];

        unique case (state_reg)
            S_INIT0: begin
                tbl_we     = 1'b1;
                tbl_waddr  = '0;
                tbl_wdata  = '0;
                state_next = S_INIT1;
            end
            S_INIT1: begin
                tbl_we     = 1'b1;
                tbl_waddr  = IW'(1);
                tbl_wdata  = PW'(CAPACITY);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next     = in_op;
                    col_next    = in_col;
                    ch_next     = in_ch;
                    dc_next     = in_dc;
                    status_next = ST_OK;
                    cout_next   = CH_NUL;
                    cval_next   = 1'b0;
                    state_next  = S_FIN;
                    unique case (in_op) inside
                        OP_SET_CURSOR: begin
                            if (in_ln == '0) begin
                                status_next = ST_RANGE;
                            end else begin
                                cl_next    = in_ln;
                                cc_next    = in_col;
                                dirty_next = 1'b1;
                            end
                        end
                        OP_INSERT, OP_DELETE: begin
                            state_next = dirty_reg ? S_EDIT : S_BODY;
                        end
                        OP_READ: begin
                            if (rq_bad) begin
                                status_next = ST_RANGE;
                            end else begin
                                pidx_next    = IW'(in_ln - 11'd1);
                                purpose_next = PU_READ;
                                state_next   = S_PR_A;
                            end
                        end
                        OP_CLEAR: begin
                            tbl_we     = 1'b1;
                            tbl_waddr  = IW'(1);
                            tbl_wdata  = PW'(CAPACITY);
                            gb_next    = '0;
                            gl_next    = PW'(CAPACITY - 1);
                            ent_next   = EW'(2);
                            cl_next    = 11'd1;
                            cc_next    = '0;
                            dirty_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDIT: begin
                ecol_next = cc_reg;
                if (ed_beyond) begin
                    if (ed_refuse) begin
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end else begin
                        pos_next    = tlen;
                        nl_rem_next = 11'(NW'(cl_reg) - NW'(lines));
                        sp_rem_next = cc_reg;
                        cl_next     = 11'(lines);
                        idx_next    = '0;
                        state_next  = S_MG_RD;
                    end
                end else begin
                    pidx_next    = IW'(cl_reg - 11'd1);
                    purpose_next = PU_EDIT;
                    state_next   = S_PR_A;
                end
            end
            S_PR_A: begin
                tbl_raddr  = pidx_reg;
                state_next = S_PR_B;
            end
            S_PR_B: begin
                ra_next    = rd;
                tbl_raddr  = pidx_reg + IW'(1);
                state_next = S_PR_C;
            end
            S_PR_C: begin
                rb_next = rd;
                case (purpose_reg)
                    PU_EDIT: state_next = S_ED_CHK;
                    PU_READ: state_next = S_RD_CHK;
                    default: state_next = S_OUT;
                endcase
            end
            S_ED_CHK: begin
                if (ck_pad > NW'(gl_reg)) begin
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end else begin
                    pos_next    = ck_pos;
                    nl_rem_next = '0;
                    sp_rem_next = 12'(ck_pad);
                    idx_next    = '0;
                    state_next  = S_MG_RD;
                end
            end
            S_MG_RD: begin
                tbl_raddr  = idx_reg[IW-1:0];
                state_next = S_MG_WR;
            end
            S_MG_WR: begin
                tbl_we    = 1'b1;
                tbl_wdata = mg_new;
                if (idx_reg == lines) begin
                    down_next = mv_down;
                    cnt_next  = mv_cnt;
                    src_next  = mv_down ? AW'(gb_reg - PW'(1)) : AW'(gb_reg + gl_reg);
                    dst_next  = mv_down ? AW'(gb_reg - PW'(1) + gl_reg) : AW'(gb_reg);
                    state_next = (mv_cnt == '0) ? S_PUT_SEL : S_MV_RD;
                end else begin
                    idx_next   = idx_reg + EW'(1);
                    state_next = S_MG_RD;
                end
            end
            S_MV_RD: begin
                txt_raddr  = src_reg;
                state_next = S_MV_WR;
            end
            S_MV_WR: begin
                txt_we    = 1'b1;
                txt_waddr = dst_reg;
                txt_wdata = txt_rdata_reg;
                cnt_next  = cnt_reg - PW'(1);
                src_next  = down_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                dst_next  = down_reg ? dst_reg - AW'(1) : dst_reg + AW'(1);
                if (cnt_reg == PW'(1)) begin
                    gb_next    = pos_reg;
                    state_next = S_PUT_SEL;
                end else begin
                    state_next = S_MV_RD;
                end
            end
            S_PUT_SEL: begin
                pc_edit_next = 1'b1;
                if (nl_rem_reg != '0) begin
                    nl_rem_next  = nl_rem_reg - 11'd1;
                    pc_char_next = CH_NEWLINE;
                    state_next   = S_PC_WR;
                end else if (sp_rem_reg != '0) begin
                    sp_rem_next  = sp_rem_reg - 12'd1;
                    pc_char_next = CH_SPACE;
                    state_next   = S_PC_WR;
                end else begin
                    cc_next    = ecol_reg;
                    dirty_next = 1'b0;
                    state_next = S_BODY;
                end
            end
            S_PC_WR: begin
                txt_we    = 1'b1;
                txt_waddr = AW'(gb_reg);
                txt_wdata = pc_char_reg;
                gb_next   = gb_reg + PW'(1);
                gl_next   = gl_reg - PW'(1);
                if (pc_char_reg == CH_NEWLINE) begin
                    cl_next    = (cl_reg == CURSOR_LINE_MAX) ? cl_reg : cl_reg + 11'd1;
                    cc_next    = '0;
                    idx_next   = ent_reg;
                    state_next = S_NL_RD;
                end else begin
                    cc_next    = (cc_reg == CURSOR_COL_MAX) ? cc_reg : cc_reg + 12'd1;
                    state_next = pc_ret;
                end
            end
            S_NL_RD: begin
                if (idx_reg == '0) begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = '0;
                    tbl_wdata  = gb_reg;
                    ent_next   = ent_reg + EW'(1);
                    state_next = pc_ret;
                end else begin
                    tbl_raddr  = IW'(idx_reg - EW'(1));
                    state_next = S_NL_CMP;
                end
            end
            S_NL_CMP: begin
                tbl_we    = 1'b1;
                tbl_waddr = idx_reg[IW-1:0];
                if (rd > gb_reg) begin
                    tbl_wdata  = rd;
                    idx_next   = idx_reg - EW'(1);
                    state_next = S_NL_RD;
                end else begin
                    tbl_wdata  = gb_reg;
                    ent_next   = ent_reg + EW'(1);
                    state_next = pc_ret;
                end
            end
            S_BODY: begin
                state_next = S_FIN;
                if (op_reg == OP_INSERT) begin
                    if (ins_full) begin
                        status_next = ST_FULL;
                    end else begin
                        pc_char_next = ch_reg;
                        pc_edit_next = 1'b0;
                        state_next   = S_PC_WR;
                    end
                end else begin
                    n_next = dl_n;
                    if (dl_back) begin
                        gb_next = gb_reg - dl_n;
                        lo_next = gb_reg - dl_n;
                    end else begin
                        lo_next = gb_reg + gl_reg;
                    end
                    gl_next  = gl_reg + dl_n;
                    idx_next = '0;
                    k_next   = '0;
                    if (dl_n != '0) begin
                        state_next = S_DW_RD;
                    end
                end
            end
            S_DW_RD: begin
                tbl_raddr  = idx_reg[IW-1:0];
                state_next = S_DW_WR;
            end
            S_DW_WR: begin
                tbl_waddr = k_reg[IW-1:0];
                tbl_wdata = rd;
                tbl_we    = !dw_drop;
                k_next    = dw_drop ? k_reg : k_reg + EW'(1);
                if (idx_reg == lines) begin
                    ent_next   = k_next;
                    state_next = S_FIN;
                end else begin
                    idx_next   = idx_reg + EW'(1);
                    state_next = S_DW_RD;
                end
            end
            S_RD_CHK: begin
                state_next = S_FIN;
                if (rd_bad) begin
                    status_next = ST_RANGE;
                end else begin
                    cval_next = 1'b1;
                    if (rd_in) begin
                        txt_raddr  = AW'(rd_phys);
                        state_next = S_RD_CAP;
                    end
                end
            end
            S_RD_CAP: begin
                cout_next  = txt_rdata_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (fin_none) begin
                    len_next   = '0;
                    state_next = S_OUT;
                end else begin
                    pidx_next    = IW'(cl_reg - 11'd1);
                    purpose_next = PU_FIN;
                    state_next   = S_PR_A;
                end
            end
            S_OUT: begin
                if (purpose_reg == PU_FIN && !fin_none) begin
                    len_next = 12'(pair_len);
                end
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, status_reg, 12'(tlen), 11'(lines),
                                     ((purpose_reg == PU_FIN && !fin_none)
                                      ? 12'(pair_len) : len_reg),
                                     cval_reg, cout_reg};
                    purpose_next  = PU_EDIT;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT0;
            gb_reg       <= '0;
            gl_reg       <= PW'(CAPACITY - 1);
            cl_reg       <= 11'd1;
            cc_reg       <= '0;
            dirty_reg    <= 1'b1;
            ent_reg      <= EW'(2);
            m_tvalid_reg <= 1'b0;
            purpose_reg  <= PU_EDIT;
        end else begin
            state_reg    <= state_next;
            gb_reg       <= gb_next;
            gl_reg       <= gl_next;
            cl_reg       <= cl_next;
            cc_reg       <= cc_next;
            dirty_reg    <= dirty_next;
            ent_reg      <= ent_next;
            m_tvalid_reg <= m_tvalid_next;
            purpose_reg  <= purpose_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        col_reg     <= col_next;
        ch_reg      <= ch_next;
        dc_reg      <= dc_next;
        pidx_reg    <= pidx_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        pos_reg     <= pos_next;
        nl_rem_reg  <= nl_rem_next;
        sp_rem_reg  <= sp_rem_next;
        ecol_reg    <= ecol_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        cnt_reg     <= cnt_next;
        down_reg    <= down_next;
        lo_reg      <= lo_next;
        n_reg       <= n_next;
        pc_char_reg <= pc_char_next;
        pc_edit_reg <= pc_edit_next;
        status_reg  <= status_next;
        cout_reg    <= cout_next;
        cval_reg    <= cval_next;
        len_reg     <= len_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
